// ----- rtl/hotp_token_check_macros.svh -----
// Assertion macros for the HOTP token checker.
// Used by hotp_token_check.sv; each macro expects clk and rst in scope.
`ifndef HOTP_TOKEN_CHECK_MACROS_SVH
`define HOTP_TOKEN_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define HOTP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hotp_token_check: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define HOTP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hotp_token_check: assertion failed");

`endif

// ----- rtl/hotp_pkg.sv -----
// Shared types and constants for the HOTP token checker.
// Used by hotp_ctrl, hotp_dp and hotp_token_check; depends on nothing.
package hotp_pkg;

  localparam int unsigned KEY_BYTES        = 20;
  localparam int unsigned STORED_KEY_BYTES = 20;
  localparam int unsigned SHA_ROUNDS       = 80;
  localparam int unsigned MOD_STEPS        = 12;
  localparam int unsigned TOKEN_MODULUS    = 1000000;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;

  localparam logic [31:0] SHA_IV0 = 32'h67452301;
  localparam logic [31:0] SHA_IV1 = 32'hefcdab89;
  localparam logic [31:0] SHA_IV2 = 32'h98badcfe;
  localparam logic [31:0] SHA_IV3 = 32'h10325476;
  localparam logic [31:0] SHA_IV4 = 32'hc3d2e1f0;

  localparam logic [31:0] SHA_K0 = 32'h5a827999;
  localparam logic [31:0] SHA_K1 = 32'h6ed9eba1;
  localparam logic [31:0] SHA_K2 = 32'h8f1bbcdc;
  localparam logic [31:0] SHA_K3 = 32'hca62c1d6;

  // Message lengths in bits: one pad block plus the tail.
  localparam logic [31:0] MSG_BITS   = 32'd576;
  localparam logic [31:0] INNER_BITS = 32'd672;

  typedef enum logic [1:0] {
    REG_KEY_FIRST  = 2'd0,
    REG_KEY_MIDDLE = 2'd1,
    REG_KEY_LAST   = 2'd2
  } reg_index_t;

  // The four compressions of one item, in order.
  typedef enum logic [1:0] {
    PASS_IPAD  = 2'd0,
    PASS_MSG   = 2'd1,
    PASS_OPAD  = 2'd2,
    PASS_INNER = 2'd3
  } pass_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_FIN   = 7'b0001000,
    S_TRUNC = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       load_block;
    pass_t      pass;
    logic       round;
    logic [6:0] round_idx;
    logic       fin;
    logic       trunc;
    logic       mod_step;
    logic [3:0] mod_shift;
    logic       out_write;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/hotp_ctrl.sv -----
// Sequencer for the HOTP token checker: walks four SHA-1 passes, truncation,
// the modulo steps and the result hand-off. Depends on hotp_pkg.
module hotp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hotp_pkg::status_t status,
  output hotp_pkg::cmd_t    cmd
);

  hotp_pkg::state_t state, state_next;
  hotp_pkg::pass_t  pass, pass_next;
  logic [6:0]       rcount, rcount_next;
  logic [3:0]       mcount, mcount_next;

  always_comb begin
    state_next    = state;
    pass_next     = pass;
    rcount_next   = rcount;
    mcount_next   = mcount;
    cmd           = '0;
    cmd.pass      = pass;
    cmd.round_idx = rcount;
    cmd.mod_shift = mcount;
    case (state)
      hotp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pass_next   = hotp_pkg::PASS_IPAD;
          state_next  = hotp_pkg::S_LOAD;
        end
      end
      hotp_pkg::S_LOAD: begin
        cmd.load_block = 1'b1;
        rcount_next    = '0;
        state_next     = hotp_pkg::S_ROUND;
      end
      hotp_pkg::S_ROUND: begin
        cmd.round   = 1'b1;
        rcount_next = rcount + 7'd1;
        if (rcount == 7'(hotp_pkg::SHA_ROUNDS - 1)) begin
          state_next = hotp_pkg::S_FIN;
        end
      end
      hotp_pkg::S_FIN: begin
        cmd.fin = 1'b1;
        if (pass == hotp_pkg::PASS_INNER) begin
          state_next = hotp_pkg::S_TRUNC;
        end else begin
          pass_next  = hotp_pkg::pass_t'(pass + 2'd1);
          state_next = hotp_pkg::S_LOAD;
        end
      end
      hotp_pkg::S_TRUNC: begin
        cmd.trunc   = 1'b1;
        mcount_next = 4'(hotp_pkg::MOD_STEPS - 1);
        state_next  = hotp_pkg::S_MOD;
      end
      hotp_pkg::S_MOD: begin
        cmd.mod_step = 1'b1;
        mcount_next  = mcount - 4'd1;
        if (mcount == '0) begin
          state_next = hotp_pkg::S_OUT;
        end
      end
      hotp_pkg::S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_write = 1'b1;
          state_next    = hotp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hotp_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != hotp_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= hotp_pkg::S_IDLE;
      pass   <= hotp_pkg::PASS_IPAD;
      rcount <= '0;
      mcount <= '0;
    end else begin
      state  <= state_next;
      pass   <= pass_next;
      rcount <= rcount_next;
      mcount <= mcount_next;
    end
  end

endmodule

// ----- rtl/hotp_dp.sv -----
// Datapath of the HOTP token checker: key registers, SHA-1 round engine with
// a 16-word schedule window, truncation, modulo unit and result register.
// Depends on hotp_pkg.
module hotp_dp (
  input  logic              clk,
  input  logic              rst,
  input  hotp_pkg::cmd_t    cmd,
  output hotp_pkg::status_t status,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic [63:0]       step_count,
  input  logic [19:0]       candidate_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [19:0]       token,
  output logic              code_valid
);

  logic [63:0]  key_first, key_middle;
  logic [31:0]  key_last;
  logic [63:0]  factor;
  logic [19:0]  candidate;
  logic [31:0]  h0, h1, h2, h3, h4;
  logic [31:0]  a, b, c, d, e;
  logic [31:0]  w [16];
  logic [159:0] inner;
  logic [30:0]  rem;

  logic [159:0] key_vec;
  logic [511:0] blk;
  logic [31:0]  f, k, t, w_new;
  logic [31:0]  s0, s1, s2, s3, s4;
  logic [159:0] digest;
  logic [7:0]   sel_hi;
  logic [31:0]  bin;
  logic [31:0]  sub;

  assign key_vec = {key_first, key_middle, key_last};

  // Message block for the current pass.
  always_comb begin
    logic [7:0] pad;
    pad = (cmd.pass == hotp_pkg::PASS_OPAD) ? hotp_pkg::OPAD_BYTE : hotp_pkg::IPAD_BYTE;
    blk = '0;
    case (cmd.pass)
      hotp_pkg::PASS_IPAD, hotp_pkg::PASS_OPAD: begin
        blk = {64{pad}};
        for (int i = 0; i < hotp_pkg::STORED_KEY_BYTES; i++) begin
          if (i < hotp_pkg::KEY_BYTES) begin
            blk[511 - 8*i -: 8] = pad ^ key_vec[159 - 8*i -: 8];
          end
        end
      end
      hotp_pkg::PASS_MSG: begin
        blk[511 -: 64]  = factor;
        blk[447 -: 32]  = 32'h80000000;
        blk[31:0]       = hotp_pkg::MSG_BITS;
      end
      hotp_pkg::PASS_INNER: begin
        blk[511 -: 160] = inner;
        blk[351 -: 32]  = 32'h80000000;
        blk[31:0]       = hotp_pkg::INNER_BITS;
      end
      default: blk = '0;
    endcase
  end

  // One SHA-1 round.
  always_comb begin
    if (cmd.round_idx < 7'd20) begin
      f = (b & c) | (~b & d);
      k = hotp_pkg::SHA_K0;
    end else if (cmd.round_idx < 7'd40) begin
      f = b ^ c ^ d;
      k = hotp_pkg::SHA_K1;
    end else if (cmd.round_idx < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = hotp_pkg::SHA_K2;
    end else begin
      f = b ^ c ^ d;
      k = hotp_pkg::SHA_K3;
    end
    t     = {a[26:0], a[31:27]} + f + e + k + w[0];
    w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  assign s0 = h0 + a;
  assign s1 = h1 + b;
  assign s2 = h2 + c;
  assign s3 = h3 + d;
  assign s4 = h4 + e;

  // Dynamic truncation: four bytes from the offset in the last nibble.
  assign digest = {h0, h1, h2, h3, h4};
  assign sel_hi = 8'd159 - {1'b0, h4[3:0], 3'b000};
  assign bin    = digest[sel_hi -: 32];
  assign sub    = 32'(hotp_pkg::TOKEN_MODULUS) << cmd.mod_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_first  <= '0;
      key_middle <= '0;
      key_last   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        hotp_pkg::REG_KEY_FIRST:  key_first  <= cfg_data;
        hotp_pkg::REG_KEY_MIDDLE: key_middle <= cfg_data;
        hotp_pkg::REG_KEY_LAST:   key_last   <= cfg_data[31:0];
        default: ;
      endcase
    end
    if (cmd.load_in) begin
      factor    <= step_count;
      candidate <= candidate_code;
    end
    if (cmd.load_block) begin
      for (int j = 0; j < 16; j++) begin
        w[j] <= blk[511 - 32*j -: 32];
      end
      if (cmd.pass == hotp_pkg::PASS_IPAD || cmd.pass == hotp_pkg::PASS_OPAD) begin
        h0 <= hotp_pkg::SHA_IV0;  a <= hotp_pkg::SHA_IV0;
        h1 <= hotp_pkg::SHA_IV1;  b <= hotp_pkg::SHA_IV1;
        h2 <= hotp_pkg::SHA_IV2;  c <= hotp_pkg::SHA_IV2;
        h3 <= hotp_pkg::SHA_IV3;  d <= hotp_pkg::SHA_IV3;
        h4 <= hotp_pkg::SHA_IV4;  e <= hotp_pkg::SHA_IV4;
      end else begin
        a <= h0;
        b <= h1;
        c <= h2;
        d <= h3;
        e <= h4;
      end
    end
    if (cmd.round) begin
      for (int j = 0; j < 15; j++) begin
        w[j] <= w[j+1];
      end
      w[15] <= w_new;
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
    if (cmd.fin) begin
      h0 <= s0;
      h1 <= s1;
      h2 <= s2;
      h3 <= s3;
      h4 <= s4;
      if (cmd.pass == hotp_pkg::PASS_MSG) begin
        inner <= {s0, s1, s2, s3, s4};
      end
    end
    if (cmd.trunc) begin
      rem <= {1'b0, bin[29:0]} | {bin[30], 30'd0};
    end
    if (cmd.mod_step && ({1'b0, rem} >= sub)) begin
      rem <= rem - sub[30:0];
    end
    if (cmd.out_write) begin
      token      <= rem[19:0];
      code_valid <= ({11'd0, candidate} == rem);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_busy = out_valid && out_stall;

endmodule

// ----- rtl/hotp_token_check.sv -----
// HOTP token checker (HMAC-SHA1, dynamic truncation, modulo one million).
// An item is a 64-bit moving factor and a candidate code; the block hashes
// the factor with the 20-byte key held in three configuration registers and
// returns one result per item: the six-digit token and a flag that is set
// when the candidate equals it. The key resets to zero. The user must write
// it through cfg_write / cfg_index / cfg_data only while no item is in
// flight; the block itself does not enforce this. Writes to index 3 are
// ignored. One item is worked at a time, from the accepting edge to the
// result register: four SHA-1 compressions on a single round engine (a load,
// 80 rounds and a chaining add each), a truncation step, twelve
// compare-subtract steps of the modulo unit and a hand-off. The input stalls
// for that whole span, so no new item is taken before the hand-off; the
// result waits in an output register, and the block starts no hand-off while
// an earlier result is still held there.
// Depends on hotp_pkg, hotp_ctrl, hotp_dp and hotp_token_check_macros.svh.
`include "hotp_token_check_macros.svh"

module hotp_token_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] step_count,
  input  logic [19:0] candidate_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] token,
  output logic        code_valid
);

  hotp_pkg::cmd_t    cmd;
  hotp_pkg::status_t status;

  // The sequencer issues one command word per cycle.
  hotp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the key, the hash state and the result register.
  hotp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .step_count     (step_count),
    .candidate_code (candidate_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .token          (token),
    .code_valid     (code_valid)
  );

  // An accepted item keeps the input closed while it is worked on.
  `HOTP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A presented token is always reduced below one million.
  `HOTP_ASSERT_NOW(a_token_range, out_valid, token < 20'd1000000)
  // A fresh result means the sequencer has gone back to idle.
  `HOTP_ASSERT_NOW(a_idle_on_result, $rose(out_valid), !in_stall)

endmodule

// ----- tb/sv/hotp_token_check_tb.sv -----
// Self-checking testbench for the HOTP token checker hotp_token_check.
// Depends on hotp_pkg and the RTL; predicts each token with its own HMAC-SHA1.
`timescale 1ns / 1ps

module hotp_token_check_tb;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = hotp_pkg::REG_KEY_FIRST;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] step_count = '0;
  logic [19:0] candidate_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [19:0] token;
  logic        code_valid;

  typedef struct {
    logic [19:0] token;
    logic        match;
  } token_result_t;

  // Expected results in the order their items were accepted.
  token_result_t pending_tokens[$];

  // Our own copy of the key registers.
  logic [63:0] key_first, key_middle;
  logic [31:0] key_last;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int matches_seen = 0;
  int idle_cycles = 0;
  int out_hold = 0;
  bit calm = 0;  // When set, neither side inserts idle cycles.

  always #5 clk = ~clk;

  hotp_token_check dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .step_count(step_count), .candidate_code(candidate_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .token(token), .code_valid(code_valid)
  );

  // One SHA-1 compression of a 512-bit block into a 160-bit chaining value.
  function automatic logic [159:0] sha1_compress(input logic [159:0] hin,
                                                 input logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int i;
    for (i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = hin[159:128]; b = hin[127:96]; c = hin[95:64]; d = hin[63:32]; e = hin[31:0];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = hotp_pkg::SHA_K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = hotp_pkg::SHA_K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = hotp_pkg::SHA_K2;
      end else begin
        f = b ^ c ^ d; k = hotp_pkg::SHA_K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c,
            hin[63:32] + d, hin[31:0] + e};
  endfunction

  // HMAC-SHA1 of the factor, dynamic truncation, then modulo one million.
  function automatic logic [19:0] hotp_token(input logic [63:0] factor);
    logic [159:0] iv, inner, digest;
    logic [511:0] key_block;
    logic [31:0]  bin;
    int off;
    iv = {hotp_pkg::SHA_IV0, hotp_pkg::SHA_IV1, hotp_pkg::SHA_IV2,
          hotp_pkg::SHA_IV3, hotp_pkg::SHA_IV4};
    key_block = {key_first, key_middle, key_last, 352'd0};
    inner = sha1_compress(iv, key_block ^ {64{hotp_pkg::IPAD_BYTE}});
    inner = sha1_compress(inner, {factor, 8'h80, 376'd0, 32'd0, hotp_pkg::MSG_BITS});
    digest = sha1_compress(iv, key_block ^ {64{hotp_pkg::OPAD_BYTE}});
    digest = sha1_compress(digest, {inner, 8'h80, 280'd0, 32'd0, hotp_pkg::INNER_BITS});
    off = digest[3:0];
    bin = digest[159 - 8 * off -: 32] & 32'h7fffffff;
    return 20'(bin % hotp_pkg::TOKEN_MODULUS);
  endfunction

  // Sends one item after a random gap and records what it must return.
  task automatic send_factor(input logic [63:0] factor, input logic [19:0] code);
    token_result_t exp_result;
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    exp_result.token = hotp_token(factor);
    exp_result.match = (code == exp_result.token);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    step_count <= factor;
    candidate_code <= code;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_tokens.push_back(exp_result);
    items_sent++;
    // Withdraw the item so it is not taken a second time.
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Picks a candidate: often the right token, sometimes a near miss,
  // otherwise anything the 20-bit field can carry.
  function automatic logic [19:0] pick_candidate(input logic [63:0] factor);
    logic [19:0] tok;
    int pick;
    tok = hotp_token(factor);
    pick = $urandom_range(0, 9);
    if (pick < 4) return tok;
    if (pick == 4) return (tok == 20'd999999) ? 20'd0 : tok + 20'd1;
    if (pick == 5) return 20'($urandom_range(1000000, 20'hfffff));
    return 20'($urandom);
  endfunction

  // Loads the key once the block is idle; an ignored write rides along.
  task automatic load_key(input logic [63:0] kf, input logic [63:0] km,
                          input logic [31:0] kl);
    while (pending_tokens.size() != 0) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= hotp_pkg::REG_KEY_FIRST;
    cfg_data <= kf;
    @(negedge clk);
    cfg_index <= hotp_pkg::REG_KEY_MIDDLE;
    cfg_data <= km;
    @(negedge clk);
    // The upper half of the data must be dropped by the 32-bit register.
    cfg_index <= hotp_pkg::REG_KEY_LAST;
    cfg_data <= {~kl, kl};
    @(negedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data <= {$urandom, $urandom};
    @(negedge clk);
    cfg_write <= 1'b0;
    key_first = kf;
    key_middle = km;
    key_last = kl;
  endtask

  // Result checker: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    token_result_t exp_result;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_tokens.size() == 0) begin
        $error("result with no item outstanding: token %0d", token);
        errors++;
      end else begin
        exp_result = pending_tokens.pop_front();
        if (token !== exp_result.token) begin
          $error("token: expected %0d, actual %0d", exp_result.token, token);
          errors++;
        end
        if (code_valid !== exp_result.match) begin
          $error("code_valid: expected %0b, actual %0b", exp_result.match, code_valid);
          errors++;
        end
        if (exp_result.match) matches_seen++;
      end
      out_hold = calm ? 0 : $urandom_range(0, 5);
    end
  end

  // The receiving side holds off each presented result for the drawn number of cycles.
  always @(negedge clk) begin
    if (out_valid && out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: too long without any handshake means the block is stuck.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // With the all-zero reset key: extremes of factor and candidate.
  task automatic test_reset_key();
    key_first = '0; key_middle = '0; key_last = '0;
    send_factor(64'd0, 20'd0);
    send_factor('1, 20'd999999);
    send_factor(64'd0, hotp_token(64'd0));
    send_factor(64'h8000_0000_0000_0000, 20'd1000000);
    send_factor(64'h0123_4567_89ab_cdef, 20'hfffff);
  endtask

  // The published test key "12345678901234567890" with counters 0 to 9.
  task automatic test_standard_vectors();
    int i;
    load_key(64'h3132333435363738, 64'h3930313233343536, 32'h37383930);
    for (i = 0; i < 10; i++) send_factor(64'(i), hotp_token(64'(i)));
  endtask

  // All-ones key with alternating bit patterns in factor and candidate, then a key with single set bits.
  task automatic test_extreme_keys();
    load_key('1, '1, '1);
    send_factor('1, hotp_token('1));
    send_factor(64'haaaa_aaaa_aaaa_aaaa, 20'haaaaa);
    send_factor(64'h5555_5555_5555_5555, 20'h55555);
    load_key(64'h8000_0000_0000_0000, 64'd0, 32'd1);
    send_factor(64'd1, hotp_token(64'd1));
    send_factor(64'hffff_ffff_0000_0000, 20'hfffff);
  endtask

  // Random phases, each under its own key; only phase 2 runs with quiet handshakes, the rest busy.
  task automatic test_random_tokens();
    logic [63:0] factor;
    int phase, n, kind;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_key('0, '0, '0);
        5: load_key('1, '1, '1);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      endcase
      calm = (phase == 2);
      for (n = 0; n < 272; n++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) factor = 64'($urandom_range(0, 1000));
        else if (kind == 1) factor = '1 - 64'($urandom_range(0, 1000));
        else factor = {$urandom, $urandom};
        send_factor(factor, pick_candidate(factor));
      end
    end
    calm = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_key();
    test_standard_vectors();
    test_extreme_keys();
    test_random_tokens();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d tokens from %0d items under ten key settings, %0d of them matches.",
             results_seen, items_sent, matches_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
